// ===== rtl/core/dcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc collision time solver package
// Shared widths, configuration register codes and side-band structures that
// travel with an item through the arithmetic chains.
// ----------------------------------------------------------------------------
package dcts_pkg;

    // Differences of two 32-bit coordinates and the sum of two radii.
    localparam int DP_W   = 33;
    localparam int RS_W   = 32;
    // Products of two differences, their sums and magnitudes.
    localparam int PROD_W = 2 * DP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = 66;
    // Wide multiplier: two limbs per operand.
    localparam int LIMB_W = MAG_W / 2;
    localparam int SQ_W   = 2 * MAG_W;
    // Discriminant and its square root.
    localparam int X_W    = SQ_W + 1;
    localparam int DISC_W = 134;
    localparam int ROOT_W = DISC_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    // Numerator, denominator and quotient of the time division.
    localparam int NUM_W  = ROOT_W + 1;
    localparam int DEN_W  = MAG_W + 1;
    localparam int QUO_W  = 32;
    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 31;
    localparam int TOL_W      = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(66);

    typedef enum logic [0:0] {
        CFG_STEP_TIME      = 1'b0,
        CFG_TIME_TOLERANCE = 1'b1
    } t_cfg_reg;

    // Values that ride along the square root chain.
    typedef struct packed {
        logic              live;
        logic              bneg;
        logic [MAG_W-1:0]  bm;
        logic [MAG_W-1:0]  a;
    } t_sq_side;

    // Values that ride along the division chain.
    typedef struct packed {
        logic ok;
        logic neg;
    } t_dv_side;

endpackage

// ===== rtl/core/dcts_wide_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stage wide unsigned multiplier
// Splits both operands into two limbs, registers the four partial products,
// then registers their aligned sum.
// ----------------------------------------------------------------------------
module dcts_wide_mul (
    input  logic                       i_clk,
    input  logic                       i_load_pp,
    input  logic                       i_load_sum,
    input  logic [dcts_pkg::MAG_W-1:0] i_a,
    input  logic [dcts_pkg::MAG_W-1:0] i_b,
    output logic [dcts_pkg::SQ_W-1:0]  o_prod
);
    import dcts_pkg::*;

    logic [2*LIMB_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [SQ_W-1:0]     r_prod;

    // Partial products of the limbs.
    always_ff @(posedge i_clk) begin
        if (i_load_pp) begin
            r_ll <= i_a[LIMB_W-1:0] * i_b[LIMB_W-1:0];
            r_lh <= i_a[LIMB_W-1:0] * i_b[MAG_W-1:LIMB_W];
            r_hl <= i_a[MAG_W-1:LIMB_W] * i_b[LIMB_W-1:0];
            r_hh <= i_a[MAG_W-1:LIMB_W] * i_b[MAG_W-1:LIMB_W];
        end
    end

    // Aligned sum of the partial products.
    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_prod <= SQ_W'(r_ll)
                    + ((SQ_W'(r_lh) + SQ_W'(r_hl)) << LIMB_W)
                    + (SQ_W'(r_hh) << (2 * LIMB_W));
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/dcts_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root: brings down two radicand
// bits, decides one root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module dcts_sqrt_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [dcts_pkg::REM_W-1:0]  i_rem,
    input  logic [dcts_pkg::ROOT_W-1:0] i_root,
    input  logic [dcts_pkg::DISC_W-1:0] i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic [dcts_pkg::REM_W-1:0]  o_rem,
    output logic [dcts_pkg::ROOT_W-1:0] o_root,
    output logic [dcts_pkg::DISC_W-1:0] o_rad,
    output logic [SIDE_W-1:0]           o_side
);
    import dcts_pkg::*;

    logic [REM_W+1:0]  w_cur;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DISC_W-1:0] r_rad;
    logic [SIDE_W-1:0] r_side;

    // Trial subtraction of (4 * root + 1) from the extended remainder.
    always_comb begin
        w_cur   = {i_rem, i_rad[DISC_W-1 -: 2]};
        w_trial = (REM_W+2)'({i_root, 2'b01});
        w_ge    = (w_cur >= w_trial);
        n_rem   = w_ge ? REM_W'(w_cur - w_trial) : REM_W'(w_cur);
        n_root  = {i_root[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[DISC_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_side = r_side;

endmodule

// ===== rtl/core/dcts_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of the unsigned division: shifts in one dividend bit,
// decides one quotient bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module dcts_div_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [dcts_pkg::DEN_W-1:0] i_rem,
    input  logic [dcts_pkg::DEN_W-1:0] i_den,
    input  logic [dcts_pkg::QUO_W-1:0] i_bits,
    input  logic [SIDE_W-1:0]          i_side,
    output logic [dcts_pkg::DEN_W-1:0] o_rem,
    output logic [dcts_pkg::DEN_W-1:0] o_den,
    output logic [dcts_pkg::QUO_W-1:0] o_bits,
    output logic [SIDE_W-1:0]          o_side
);
    import dcts_pkg::*;

    logic [DEN_W:0]    w_cur;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_bits;
    logic [SIDE_W-1:0] r_side;

    // Compare and subtract the denominator; the bit register shifts out
    // dividend bits at the top and takes quotient bits at the bottom.
    always_comb begin
        w_cur = {i_rem, i_bits[QUO_W-1]};
        w_ge  = (w_cur >= {1'b0, i_den});
        n_rem = w_ge ? DEN_W'(w_cur - {1'b0, i_den}) : DEN_W'(w_cur);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_bits <= {i_bits[QUO_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_bits = r_bits;
    assign o_side = r_side;

endmodule

// ===== rtl/core/disc_collision_time_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc collision time solver
// Solves |dp + t*dv| = r1 + r2 for two moving discs and reports the earliest
// touching time inside the step window, in signed fixed point.
//
//   Channel   Direction  Handshake               Payload
//   input     in         i_in_valid/o_in_ready   i_first_*, i_second_*
//   result    out        o_out_valid/i_out_ready o_will_collide, o_hit_time
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle is taken unless every stage is full and the result
// is held; every request passes 109 register stages: the 67-cell square root
// chain, the 32-cell division chain and ten arithmetic stages. Each stage
// holds its own valid bit, so bubbles collapse and new requests are taken
// while a result waits, as long as a stage is empty.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults. The configuration port is always ready.
// ----------------------------------------------------------------------------
module disc_collision_time_solver #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [31:0]              i_first_x,
    input  logic signed [31:0]              i_first_y,
    input  logic signed [31:0]              i_first_vx,
    input  logic signed [31:0]              i_first_vy,
    input  logic [30:0]                     i_first_radius,
    input  logic signed [31:0]              i_second_x,
    input  logic signed [31:0]              i_second_y,
    input  logic signed [31:0]              i_second_vx,
    input  logic signed [31:0]              i_second_vy,
    input  logic [30:0]                     i_second_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_will_collide,
    output logic signed [31:0]              o_hit_time,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  dcts_pkg::t_cfg_reg              i_cfg_index,
    input  logic [dcts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dcts_pkg::*;

    // Stage positions along the pipeline.
    localparam int ST_DIFF = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_MAG  = 3;
    localparam int ST_MUL0 = 4;
    localparam int ST_MUL1 = 5;
    localparam int ST_DISC = 6;
    localparam int ST_SQ0  = 7;
    localparam int ST_NUM  = ST_SQ0 + ROOT_W;
    localparam int ST_PREP = ST_NUM + 1;
    localparam int ST_DV0  = ST_PREP + 1;
    localparam int ST_OUT  = ST_DV0 + QUO_W;
    localparam int NST     = ST_OUT + 1;
    // Dividend bits below the quotient window.
    localparam int LOW_W   = QUO_W - FRACTION_BITS;

    typedef struct packed {
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] bm;
        logic             bneg;
        logic             cneg;
    } t_mul_side;

    // Configuration registers.
    logic [STEP_W-1:0] r_step;
    logic [TOL_W-1:0]  r_tol;

    // Pipeline control.
    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] w_en;

    // Early arithmetic stages.
    logic signed [DP_W-1:0]   r_dpx, r_dpy, r_dvx, r_dvy;
    logic [RS_W-1:0]          r_rs;
    logic signed [PROD_W-1:0] r_vxx, r_vyy, r_pvx, r_pvy, r_pxx, r_pyy;
    logic [2*RS_W-1:0]        r_rss;
    logic [MAG_W-1:0]         r_a2;
    logic signed [SUM_W-1:0]  r_bs, r_cs;
    logic [MAG_W-1:0]         r_a3, r_bm3, r_cm3;
    logic                     r_bneg3, r_cneg3;
    t_mul_side                r_ms4, r_ms5;
    logic [SQ_W-1:0]          w_pb, w_pc;
    logic signed [X_W-1:0]    w_x;
    logic [DISC_W-1:0]        r_disc;
    t_sq_side                 r_sqs;

    // Square root chain links.
    logic [REM_W-1:0]  w_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_sq_root [ROOT_W+1];
    logic [DISC_W-1:0] w_sq_rad  [ROOT_W+1];
    t_sq_side          w_sq_side [ROOT_W+1];

    // Numerator stage.
    t_sq_side          w_sqo;
    logic [NUM_W-1:0]  w_twob, w_dext;
    logic [NUM_W-1:0]  n_nmag;
    logic              n_nneg;
    logic [NUM_W-1:0]  r_nmag;
    logic              r_nneg, r_nlive;
    logic [DEN_W-1:0]  r_nden;
    logic [NUM_W-1:0]  w_hi;
    logic              w_ovf;
    logic [DEN_W-1:0]  r_prem;
    logic [DEN_W-1:0]  r_pden;
    logic [QUO_W-1:0]  r_pbits;
    t_dv_side          r_pside;

    // Division chain links.
    logic [DEN_W-1:0]  w_dv_rem  [QUO_W+1];
    logic [DEN_W-1:0]  w_dv_den  [QUO_W+1];
    logic [QUO_W-1:0]  w_dv_bits [QUO_W+1];
    t_dv_side          w_dv_side [QUO_W+1];

    // Result stage.
    t_dv_side          w_dvo;
    logic [QUO_W:0]    w_qc;
    logic              n_collide;
    logic [QUO_W-1:0]  n_hit;
    logic              r_collide;
    logic [QUO_W-1:0]  r_hit;

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_tol  <= TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_TIME:      r_step <= i_cfg_data[STEP_W-1:0];
                CFG_TIME_TOLERANCE: r_tol  <= i_cfg_data[TOL_W-1:0];
            endcase
        end
    end

    // A stage loads when it or any stage after it is empty, or when the result is taken.
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = i_out_ready || !(&r_v[NST-1:k]);
    end

    always_comb begin
        n_v[0] = w_en[0] ? i_in_valid : r_v[0];
        for (int k = 1; k < NST; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NST-1];

    // Relative position, relative velocity and radius sum.
    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            r_dpx <= $signed({i_first_x[31], i_first_x}) - $signed({i_second_x[31], i_second_x});
            r_dpy <= $signed({i_first_y[31], i_first_y}) - $signed({i_second_y[31], i_second_y});
            r_dvx <= $signed({i_first_vx[31], i_first_vx})
                   - $signed({i_second_vx[31], i_second_vx});
            r_dvy <= $signed({i_first_vy[31], i_first_vy})
                   - $signed({i_second_vy[31], i_second_vy});
            r_rs  <= {1'b0, i_first_radius} + {1'b0, i_second_radius};
        end
    end

    // Component products.
    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_vxx <= r_dvx * r_dvx;
            r_vyy <= r_dvy * r_dvy;
            r_pvx <= r_dpx * r_dvx;
            r_pvy <= r_dpy * r_dvy;
            r_pxx <= r_dpx * r_dpx;
            r_pyy <= r_dpy * r_dpy;
            r_rss <= r_rs * r_rs;
        end
    end

    // Quadratic coefficients A, B/2 and C.
    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_a2 <= MAG_W'($unsigned(r_vxx)) + MAG_W'($unsigned(r_vyy));
            r_bs <= SUM_W'(r_pvx) + SUM_W'(r_pvy);
            r_cs <= SUM_W'(r_pxx) + SUM_W'(r_pyy) - $signed(SUM_W'(r_rss));
        end
    end

    // Sign and magnitude of B/2 and C.
    always_ff @(posedge i_clk) begin
        if (w_en[ST_MAG]) begin
            r_a3    <= r_a2;
            r_bneg3 <= r_bs[SUM_W-1];
            r_bm3   <= MAG_W'(r_bs[SUM_W-1] ? -r_bs : r_bs);
            r_cneg3 <= r_cs[SUM_W-1];
            r_cm3   <= MAG_W'(r_cs[SUM_W-1] ? -r_cs : r_cs);
        end
    end

    // (B/2)^2 and A*|C|.
    dcts_wide_mul u_mul_b (
        .i_clk      (i_clk),
        .i_load_pp  (w_en[ST_MUL0]),
        .i_load_sum (w_en[ST_MUL1]),
        .i_a        (r_bm3),
        .i_b        (r_bm3),
        .o_prod     (w_pb)
    );

    dcts_wide_mul u_mul_c (
        .i_clk      (i_clk),
        .i_load_pp  (w_en[ST_MUL0]),
        .i_load_sum (w_en[ST_MUL1]),
        .i_a        (r_a3),
        .i_b        (r_cm3),
        .o_prod     (w_pc)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL0]) begin
            r_ms4 <= '{a: r_a3, bm: r_bm3, bneg: r_bneg3, cneg: r_cneg3};
        end
        if (w_en[ST_MUL1]) begin
            r_ms5 <= r_ms4;
        end
    end

    // Discriminant B^2 - 4AC, formed as four times (B/2)^2 - AC.
    always_comb begin
        if (r_ms5.cneg) begin
            w_x = $signed({1'b0, w_pb} + {1'b0, w_pc});
        end else begin
            w_x = $signed({1'b0, w_pb} - {1'b0, w_pc});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DISC]) begin
            r_disc <= {w_x[DISC_W-3:0], 2'b00};
            r_sqs  <= '{live: (r_ms5.a != '0) && !w_x[X_W-1],
                        bneg: r_ms5.bneg, bm: r_ms5.bm, a: r_ms5.a};
        end
    end

    // Square root chain.
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = r_disc;
    assign w_sq_side[0] = r_sqs;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        dcts_sqrt_cell #(
            .SIDE_W ($bits(t_sq_side))
        ) u_cell (
            .i_clk  (i_clk),
            .i_load (w_en[ST_SQ0+k]),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .i_rad  (w_sq_rad[k]),
            .i_side (w_sq_side[k]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1]),
            .o_rad  (w_sq_rad[k+1]),
            .o_side (w_sq_side[k+1])
        );
    end

    // Numerator -B - D as sign and magnitude, denominator 2A.
    always_comb begin
        w_sqo  = w_sq_side[ROOT_W];
        w_twob = NUM_W'({w_sqo.bm, 1'b0});
        w_dext = NUM_W'(w_sq_root[ROOT_W]);
        if (w_sqo.bneg) begin
            n_nneg = (w_dext > w_twob);
            n_nmag = n_nneg ? (w_dext - w_twob) : (w_twob - w_dext);
        end else begin
            n_nmag = w_twob + w_dext;
            n_nneg = (n_nmag != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) begin
            r_nmag  <= n_nmag;
            r_nneg  <= n_nneg;
            r_nlive <= w_sqo.live;
            r_nden  <= {w_sqo.a, 1'b0};
        end
    end

    // Division setup: a quotient of 2^32 or more can never be a hit.
    always_comb begin
        w_hi  = r_nmag >> LOW_W;
        w_ovf = (w_hi >= NUM_W'(r_nden));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PREP]) begin
            r_prem  <= DEN_W'(w_hi);
            r_pden  <= r_nden;
            r_pbits <= {r_nmag[LOW_W-1:0], {FRACTION_BITS{1'b0}}};
            r_pside <= '{ok: r_nlive && !w_ovf, neg: r_nneg};
        end
    end

    // Division chain.
    assign w_dv_rem[0]  = r_prem;
    assign w_dv_den[0]  = r_pden;
    assign w_dv_bits[0] = r_pbits;
    assign w_dv_side[0] = r_pside;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        dcts_div_cell #(
            .SIDE_W ($bits(t_dv_side))
        ) u_cell (
            .i_clk  (i_clk),
            .i_load (w_en[ST_DV0+k]),
            .i_rem  (w_dv_rem[k]),
            .i_den  (w_dv_den[k]),
            .i_bits (w_dv_bits[k]),
            .i_side (w_dv_side[k]),
            .o_rem  (w_dv_rem[k+1]),
            .o_den  (w_dv_den[k+1]),
            .o_bits (w_dv_bits[k+1]),
            .o_side (w_dv_side[k+1])
        );
    end

    // Window test: a negative time rounds away from zero and must stay
    // above -tolerance, a positive time must stay below the step length.
    always_comb begin
        w_dvo = w_dv_side[QUO_W];
        w_qc  = {1'b0, w_dv_bits[QUO_W]} + (QUO_W+1)'(|w_dv_rem[QUO_W]);
        if (w_dvo.neg) begin
            n_collide = w_dvo.ok && (w_qc < (QUO_W+1)'(r_tol));
            n_hit     = QUO_W'((QUO_W+1)'(0) - w_qc);
        end else begin
            n_collide = w_dvo.ok && ({1'b0, w_dv_bits[QUO_W]} < (QUO_W+1)'(r_step));
            n_hit     = w_dv_bits[QUO_W];
        end
        if (!n_collide) begin
            n_hit = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_collide <= n_collide;
            r_hit     <= n_hit;
        end
    end

    assign o_will_collide = r_collide;
    assign o_hit_time     = $signed(r_hit);

    // Input is refused only when every stage holds an item.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_v))
        else $error("input refused with an empty stage");

    // A miss carries a zero time.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_will_collide) |-> (o_hit_time == 32'sd0))
        else $error("miss with nonzero time");

    // A negative hit time lies within the largest tolerance.
    a_neg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_will_collide && o_hit_time[31]) |->
        (o_hit_time >= -32'sd65535))
        else $error("negative hit time beyond tolerance range");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
